// ----- rtl/plob_pkg.sv -----
// plob_pkg: sizes, codes and item types for the price level order book
// no dependencies; used by every rtl file of the block
`timescale 1ns / 1ps
`default_nettype none

package plob_pkg;

    localparam int LEVELS     = 64;
    localparam int PRICE_BITS = 32;
    localparam int QTY_BITS   = 32;
    localparam int CNT_BITS   = $clog2(LEVELS + 1);
    localparam int UPD_BITS   = 32;

    typedef logic [PRICE_BITS-1:0] t_price;
    typedef logic [QTY_BITS-1:0]   t_qty;
    typedef logic [CNT_BITS-1:0]   t_cnt;

    typedef enum logic [1:0] {
        OP_NEW = 2'd0,
        OP_DEL = 2'd1,
        OP_CHG = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0] op;
        logic       side;
        t_price     price;
        t_qty       quantity;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        t_qty                level_quantity;
        t_price              best_bid_price;
        t_qty                best_bid_quantity;
        t_price              best_ask_price;
        t_qty                best_ask_quantity;
        t_cnt                bid_level_count;
        t_cnt                ask_level_count;
        logic [UPD_BITS-1:0] update_count;
    } t_out_item;

    // one price level held by a cell
    typedef struct packed {
        logic   valid;
        t_price price;
        t_qty   qty;
    } t_level;

    // broadcast from the sequencer to every cell of one side
    typedef struct packed {
        logic   look;
        logic   ins;
        logic   rm;
        logic   set;
        t_price price;
        t_qty   qty;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ----- rtl/plob_cell.sv -----
// plob_cell: one price level slot of a sorted side, with shift left and right
// depends on plob_pkg
`timescale 1ns / 1ps
`default_nettype none

module plob_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_is_ask,
    input  plob_pkg::t_cell_cmd i_cmd,
    input  plob_pkg::t_level   i_prev,
    input  logic               i_prev_aft,
    input  plob_pkg::t_level   i_next,
    output plob_pkg::t_level   o_level,
    output logic               o_aft,
    output logic               o_eq
);
    import plob_pkg::*;

    t_level r_level;
    t_level n_level;
    logic   r_aft;
    logic   r_eq;
    logic   better;
    logic   aft;
    logic   eq;
    logic   at_pos;

    always_comb begin
        better = i_is_ask ? (r_level.price < i_cmd.price) : (r_level.price > i_cmd.price);
        aft    = !r_level.valid || !better;
        eq     = r_level.valid && (r_level.price == i_cmd.price);
        at_pos = r_aft && !i_prev_aft;
        n_level = r_level;
        if (i_cmd.ins && r_aft) begin
            if (at_pos) begin
                n_level.valid = 1'b1;
                n_level.price = i_cmd.price;
                n_level.qty   = i_cmd.qty;
            end else begin
                n_level = i_prev;
            end
        end else if (i_cmd.rm && r_aft) begin
            n_level = i_next;
        end else if (i_cmd.set && r_eq) begin
            n_level.qty = i_cmd.qty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level.valid <= 1'b0;
            r_aft         <= 1'b0;
            r_eq          <= 1'b0;
        end else begin
            r_level <= n_level;
            if (i_cmd.look) begin
                r_aft <= aft;
                r_eq  <= eq;
            end
        end
    end

    assign o_level = r_level;
    assign o_aft   = r_aft;
    assign o_eq    = r_eq;

endmodule

`default_nettype wire

// ----- rtl/plob_chain.sv -----
// plob_chain: row of level cells for one side plus match and quantity gather
// depends on plob_pkg and plob_cell
`timescale 1ns / 1ps
`default_nettype none

module plob_chain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_is_ask,
    input  plob_pkg::t_cell_cmd i_cmd,
    output logic               o_match,
    output plob_pkg::t_qty     o_old_qty,
    output plob_pkg::t_level   o_top
);
    import plob_pkg::*;

    t_level lv  [LEVELS];
    logic   aft [LEVELS];
    logic   eq  [LEVELS];

    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        t_level prev_lv;
        t_level next_lv;
        logic   prev_aft;

        if (g == 0) begin : g_first
            assign prev_lv  = '0;
            assign prev_aft = 1'b0;
        end else begin : g_inner
            assign prev_lv  = lv[g-1];
            assign prev_aft = aft[g-1];
        end

        if (g == LEVELS - 1) begin : g_last
            assign next_lv = '0;
        end else begin : g_body
            assign next_lv = lv[g+1];
        end

        plob_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_is_ask   (i_is_ask),
            .i_cmd      (i_cmd),
            .i_prev     (prev_lv),
            .i_prev_aft (prev_aft),
            .i_next     (next_lv),
            .o_level    (lv[g]),
            .o_aft      (aft[g]),
            .o_eq       (eq[g])
        );
    end

    always_comb begin
        o_match   = 1'b0;
        o_old_qty = '0;
        for (int i = 0; i < LEVELS; i++) begin
            o_match   = o_match | eq[i];
            o_old_qty = o_old_qty | (eq[i] ? lv[i].qty : '0);
        end
    end

    assign o_top = lv[0];

endmodule

`default_nettype wire

// ----- rtl/price_level_order_book.sv -----
// price_level_order_book: bid and ask level chains with a four step sequencer
// steps: look, gather, apply, report, then idle again to accept the next item
// one item in flight: a new item is accepted only once the last result is registered;
// the gather of the matched level across all cells is a step of its own
// reset: both sides empty, level counts and update count zero, no result pending
// depends on plob_pkg and plob_chain
`timescale 1ns / 1ps
`default_nettype none

module price_level_order_book (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  plob_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output plob_pkg::t_out_item o_out_item
);
    import plob_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_GATHER,
        S_APPLY,
        S_DONE
    } t_state;

    t_state              r_state;
    t_in_item            r_item;
    logic                r_match;
    t_qty                r_old_qty;
    logic [1:0]          r_status;
    t_qty                r_lvl_qty;
    t_cnt                r_bid_cnt;
    t_cnt                r_ask_cnt;
    logic [UPD_BITS-1:0] r_upd;
    logic                r_out_valid;
    t_out_item           r_out_item;

    t_cell_cmd           base_cmd;
    t_cell_cmd           bid_cmd;
    t_cell_cmd           ask_cmd;
    logic                bid_match;
    logic                ask_match;
    t_qty                bid_old_qty;
    t_qty                ask_old_qty;
    t_level              bid_top;
    t_level              ask_top;

    logic [QTY_BITS:0]   sum;
    t_qty                add_q;
    t_qty                sub_q;
    t_cnt                side_cnt;
    logic                full;
    logic [1:0]          d_status;
    t_qty                d_lvl;
    t_qty                d_qty;
    logic                d_ins;
    logic                d_rm;
    logic                d_set;

    always_comb begin
        sum      = {1'b0, r_old_qty} + {1'b0, r_item.quantity};
        add_q    = sum[QTY_BITS] ? '1 : sum[QTY_BITS-1:0];
        sub_q    = (r_old_qty > r_item.quantity) ? (r_old_qty - r_item.quantity) : '0;
        side_cnt = r_item.side ? r_ask_cnt : r_bid_cnt;
        full     = (side_cnt == CNT_BITS'(LEVELS));
        d_status = ST_OK;
        d_lvl    = '0;
        d_qty    = r_item.quantity;
        d_ins    = 1'b0;
        d_rm     = 1'b0;
        d_set    = 1'b0;
        case (r_item.op)
            OP_NEW: begin
                if (r_match) begin
                    d_set = 1'b1;
                    d_qty = add_q;
                    d_lvl = add_q;
                end else if (full) begin
                    d_status = ST_FULL;
                end else begin
                    d_ins = 1'b1;
                    d_lvl = r_item.quantity;
                end
            end
            OP_DEL: begin
                if (!r_match) begin
                    d_status = ST_NOT_FOUND;
                end else begin
                    d_lvl = sub_q;
                    d_qty = sub_q;
                    if (sub_q == '0) begin
                        d_rm = 1'b1;
                    end else begin
                        d_set = 1'b1;
                    end
                end
            end
            OP_CHG: begin
                if (!r_match) begin
                    d_status = ST_NOT_FOUND;
                end else begin
                    d_set = 1'b1;
                    d_lvl = r_item.quantity;
                end
            end
            default: begin
                d_lvl = r_match ? r_old_qty : '0;
            end
        endcase
    end

    always_comb begin
        base_cmd.look  = (r_state == S_LOOK);
        base_cmd.ins   = (r_state == S_APPLY) && d_ins;
        base_cmd.rm    = (r_state == S_APPLY) && d_rm;
        base_cmd.set   = (r_state == S_APPLY) && d_set;
        base_cmd.price = r_item.price;
        base_cmd.qty   = d_qty;
        bid_cmd = base_cmd;
        ask_cmd = base_cmd;
        if (r_item.side) begin
            bid_cmd.look = 1'b0;
            bid_cmd.ins  = 1'b0;
            bid_cmd.rm   = 1'b0;
            bid_cmd.set  = 1'b0;
        end else begin
            ask_cmd.look = 1'b0;
            ask_cmd.ins  = 1'b0;
            ask_cmd.rm   = 1'b0;
            ask_cmd.set  = 1'b0;
        end
    end

    plob_chain u_bid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_is_ask  (1'b0),
        .i_cmd     (bid_cmd),
        .o_match   (bid_match),
        .o_old_qty (bid_old_qty),
        .o_top     (bid_top)
    );

    plob_chain u_ask (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_is_ask  (1'b1),
        .i_cmd     (ask_cmd),
        .o_match   (ask_match),
        .o_old_qty (ask_old_qty),
        .o_top     (ask_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bid_cnt   <= '0;
            r_ask_cnt   <= '0;
            r_upd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_item;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_GATHER;
                end
                S_GATHER: begin
                    r_match   <= r_item.side ? ask_match : bid_match;
                    r_old_qty <= r_item.side ? ask_old_qty : bid_old_qty;
                    r_state   <= S_APPLY;
                end
                S_APPLY: begin
                    r_status  <= d_status;
                    r_lvl_qty <= d_lvl;
                    r_upd     <= r_upd + UPD_BITS'(1);
                    if (d_ins) begin
                        if (r_item.side) begin
                            r_ask_cnt <= r_ask_cnt + CNT_BITS'(1);
                        end else begin
                            r_bid_cnt <= r_bid_cnt + CNT_BITS'(1);
                        end
                    end else if (d_rm) begin
                        if (r_item.side) begin
                            r_ask_cnt <= r_ask_cnt - CNT_BITS'(1);
                        end else begin
                            r_bid_cnt <= r_bid_cnt - CNT_BITS'(1);
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid                  <= 1'b1;
                        r_out_item.status            <= r_status;
                        r_out_item.level_quantity    <= r_lvl_qty;
                        r_out_item.best_bid_price    <= bid_top.valid ? bid_top.price : '0;
                        r_out_item.best_bid_quantity <= bid_top.valid ? bid_top.qty : '0;
                        r_out_item.best_ask_price    <= ask_top.valid ? ask_top.price : '0;
                        r_out_item.best_ask_quantity <= ask_top.valid ? ask_top.qty : '0;
                        r_out_item.bid_level_count   <= r_bid_cnt;
                        r_out_item.ask_level_count   <= r_ask_cnt;
                        r_out_item.update_count      <= r_upd;
                        r_state                      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- rtl/plob_checker.sv -----
// plob_checker: port level checks for price_level_order_book, bound to the top
// depends on plob_pkg and price_level_order_book
`timescale 1ns / 1ps
`default_nettype none

module plob_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input plob_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input plob_pkg::t_out_item o_out_item
);
    import plob_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready while an item is in flight");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_FULL) |->
            (o_out_item.bid_level_count == CNT_BITS'(LEVELS)) ||
            (o_out_item.ask_level_count == CNT_BITS'(LEVELS)))
        else $error("full status with no full side");

    a_empty_bid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.bid_level_count == '0) |->
            (o_out_item.best_bid_price == '0) && (o_out_item.best_bid_quantity == '0))
        else $error("best bid reported on empty side");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.bid_level_count <= CNT_BITS'(LEVELS)) &&
            (o_out_item.ask_level_count <= CNT_BITS'(LEVELS)))
        else $error("level count above table depth");

endmodule

bind price_level_order_book plob_checker u_plob_checker (.*);

`default_nettype wire

// ----- test/testbench.sv -----
// testbench for price_level_order_book: random and directed book entries checked against
// an in-bench level-table predictor, with random idling on both handshakes
// depends on plob_pkg and the price_level_order_book rtl
`timescale 1ns / 1ps

module testbench;
    import plob_pkg::*;

    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic        SIDE_BID    = 1'b0;
    localparam logic        SIDE_ASK    = 1'b1;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASE_ITEMS = 260;
    localparam logic [31:0] BASE_LOW    = 32'd0;
    localparam logic [31:0] BASE_MID    = 32'd5000;
    localparam logic [31:0] BASE_TOP    = 32'hFFFF_FF9F;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    t_in_item    entry_q[$];
    t_out_item   book_expect_q[$];
    t_out_item   want_item;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          faults = 0;
    int          pushed = 0;
    int unsigned cycles = 0;
    logic        hold_arm = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;
    logic [31:0] pool_base = BASE_MID;

    // predictor copy of the book; index 0 is the bid side, 1 the ask side
    t_price      book_px[2][LEVELS] = '{default: '0};
    t_qty        book_qt[2][LEVELS] = '{default: '0};
    int          book_depth[2] = '{0, 0};
    logic [31:0] entries_seen = '0;

    price_level_order_book DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic t_out_item apply_entry(t_in_item e);
        int               s;
        int               n;
        int               pos;
        int               k;
        logic             hit;
        logic [QTY_BITS:0] sum;
        t_qty             lq;
        t_out_item        r;
        s = int'(e.side);
        n = book_depth[s];
        pos = 0;
        while (pos < n) begin
            if (e.side == SIDE_ASK ? (book_px[s][pos] >= e.price)
                                   : (book_px[s][pos] <= e.price)) break;
            pos++;
        end
        hit = (pos < n) && (book_px[s][pos] == e.price);
        r = '0;
        r.status = ST_OK;
        lq = '0;
        case (e.op)
            OP_NEW: begin
                if (hit) begin
                    sum = {1'b0, book_qt[s][pos]} + {1'b0, e.quantity};
                    book_qt[s][pos] = sum[QTY_BITS] ? '1 : sum[QTY_BITS-1:0];
                    lq = book_qt[s][pos];
                end else if (n >= LEVELS) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = n; k > pos; k--) begin
                        book_px[s][k] = book_px[s][k-1];
                        book_qt[s][k] = book_qt[s][k-1];
                    end
                    book_px[s][pos] = e.price;
                    book_qt[s][pos] = e.quantity;
                    n++;
                    lq = e.quantity;
                end
            end
            OP_DEL: begin
                if (!hit) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    lq = (book_qt[s][pos] > e.quantity) ? book_qt[s][pos] - e.quantity : '0;
                    if (lq == '0) begin
                        for (k = pos; k + 1 < n; k++) begin
                            book_px[s][k] = book_px[s][k+1];
                            book_qt[s][k] = book_qt[s][k+1];
                        end
                        n--;
                        book_px[s][n] = '0;
                        book_qt[s][n] = '0;
                    end else begin
                        book_qt[s][pos] = lq;
                    end
                end
            end
            OP_CHG: begin
                if (!hit) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    book_qt[s][pos] = e.quantity;
                    lq = e.quantity;
                end
            end
            default: begin
                if (hit) lq = book_qt[s][pos];
            end
        endcase
        book_depth[s] = n;
        entries_seen = entries_seen + 32'd1;
        r.level_quantity    = lq;
        r.best_bid_price    = book_depth[0] != 0 ? book_px[0][0] : '0;
        r.best_bid_quantity = book_depth[0] != 0 ? book_qt[0][0] : '0;
        r.best_ask_price    = book_depth[1] != 0 ? book_px[1][0] : '0;
        r.best_ask_quantity = book_depth[1] != 0 ? book_qt[1][0] : '0;
        r.bid_level_count   = t_cnt'(book_depth[0]);
        r.ask_level_count   = t_cnt'(book_depth[1]);
        r.update_count      = entries_seen;
        return r;
    endfunction

    function automatic string fmt_book(t_out_item r);
        return $sformatf("st=%0d lq=%h bid=%h/%h ask=%h/%h lvls=%0d/%0d upd=%0d",
                         r.status, r.level_quantity, r.best_bid_price,
                         r.best_bid_quantity, r.best_ask_price, r.best_ask_quantity,
                         r.bid_level_count, r.ask_level_count, r.update_count);
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end else begin
            if (in_valid && in_ready) book_expect_q.push_back(apply_entry(in_item));
            if (!in_valid || in_ready) begin
                if (entry_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    in_item  <= entry_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_arm && !hold_taken) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (book_expect_q.size() == 0) begin
                    faults++;
                    if (faults <= 10) $display("unexpected result: %s", fmt_book(out_item));
                end else begin
                    want_item = book_expect_q.pop_front();
                    if (want_item.status !== out_item.status
                        || want_item.level_quantity !== out_item.level_quantity
                        || want_item.best_bid_price !== out_item.best_bid_price
                        || want_item.best_bid_quantity !== out_item.best_bid_quantity
                        || want_item.best_ask_price !== out_item.best_ask_price
                        || want_item.best_ask_quantity !== out_item.best_ask_quantity
                        || want_item.bid_level_count !== out_item.bid_level_count
                        || want_item.ask_level_count !== out_item.ask_level_count
                        || want_item.update_count !== out_item.update_count) begin
                        faults++;
                        if (faults <= 10) begin
                            $display("mismatch expected %s", fmt_book(want_item));
                            $display("         actual   %s", fmt_book(out_item));
                        end
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_entry(logic [1:0] op, logic side, t_price price, t_qty qty);
        t_in_item e;
        e.op       = op;
        e.side     = side;
        e.price    = price;
        e.quantity = qty;
        entry_q.push_back(e);
        pushed++;
    endtask

    function automatic t_qty rand_lots();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return t_qty'($urandom_range(1, 100));
            3:       return t_qty'(32'hFFFF_FF00 | $urandom_range(0, 255));
            default: return t_qty'($urandom);
        endcase
    endfunction

    function automatic t_price pool_price();
        return t_price'(pool_base + $urandom_range(0, 96));
    endfunction

    function automatic logic [1:0] rand_op();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return OP_UNUSED;
        if (r <= 8) return OP_NEW;
        if (r <= 14) return OP_DEL;
        return OP_CHG;
    endfunction

    task automatic gen_burst();
        int  kind;
        int  i;
        int  r;
        logic s;
        kind = $urandom_range(0, 9);
        s = 1'($urandom);
        case ($urandom_range(0, 2))
            0:       pool_base = BASE_LOW;
            1:       pool_base = BASE_MID;
            default: pool_base = BASE_TOP;
        endcase
        if (kind <= 2) begin
            // distinct prices so one side runs full
            for (i = 0; i < 80; i++) begin
                if ($urandom_range(0, 99) < 85)
                    push_entry(OP_NEW, s, t_price'(pool_base + (i * 37) % 97),
                               t_qty'($urandom_range(1, 1000)));
                else
                    push_entry(rand_op(), 1'($urandom), pool_price(), rand_lots());
            end
        end else if (kind <= 5) begin
            for (i = 0; i < 80; i++) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    push_entry(OP_DEL, s, pool_price(), r < 35 ? '1 : rand_lots());
                else if (r < 85)
                    push_entry(OP_CHG, s, pool_price(), rand_lots());
                else
                    push_entry(OP_NEW, 1'($urandom), pool_price(), rand_lots());
            end
        end else if (kind <= 8) begin
            for (i = 0; i < 60; i++)
                push_entry(rand_op(), 1'($urandom), pool_price(), rand_lots());
        end else begin
            for (i = 0; i < 20; i++)
                push_entry(2'($urandom_range(0, 3)), 1'($urandom), t_price'($urandom),
                           t_qty'($urandom));
        end
    endtask

    initial begin
        int ph;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_entry(OP_NEW, SIDE_BID, 32'd100, 32'd10);
        push_entry(OP_NEW, SIDE_BID, 32'd100, '1);
        push_entry(OP_NEW, SIDE_ASK, 32'hFFFF_FFFF, '0);
        push_entry(OP_NEW, SIDE_ASK, 32'd0, 32'd5);
        push_entry(OP_NEW, SIDE_BID, 32'hFFFF_FFFF, 32'd7);
        push_entry(OP_NEW, SIDE_BID, 32'd0, 32'hAAAA_AAAA);
        push_entry(OP_NEW, SIDE_BID, 32'h5555_5555, 32'h5555_5555);
        push_entry(OP_DEL, SIDE_BID, 32'd55, 32'd1);
        push_entry(OP_CHG, SIDE_ASK, 32'd77, 32'd1);
        push_entry(OP_CHG, SIDE_ASK, 32'd0, '0);
        push_entry(OP_DEL, SIDE_BID, 32'd100, 32'd1);
        push_entry(OP_DEL, SIDE_BID, 32'd100, '1);
        push_entry(OP_UNUSED, SIDE_BID, 32'hFFFF_FFFF, 32'd3);
        push_entry(OP_UNUSED, SIDE_ASK, 32'd12345, 32'd3);
        push_entry(OP_CHG, SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_entry(OP_NEW, SIDE_BID, 32'hFFFF_FFFF, 32'd1);
        push_entry(OP_DEL, SIDE_ASK, 32'hFFFF_FFFF, '0);
        push_entry(OP_DEL, SIDE_ASK, 32'd0, 32'd0);
        push_entry(OP_NEW, SIDE_ASK, 32'd8, 32'd9);
        push_entry(OP_NEW, SIDE_ASK, 32'd4, 32'd2);
        push_entry(OP_NEW, SIDE_ASK, 32'd6, 32'd3);
        push_entry(OP_DEL, SIDE_ASK, 32'd6, 32'd3);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 54; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            if (ph == 0) hold_arm = 1'b1;
            pushed = 0;
            while (pushed < PHASE_ITEMS) gen_burst();
            while (entry_q.size() != 0 || in_valid) @(negedge clk);
        end

        while (book_expect_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (faults == 0 && book_expect_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
